// ===== hdl/cba_pkg.sv =====
// ----------------------------------------------------------------------------
// cba_pkg
// Shared types and constants of the contiguous block allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package cba_pkg;

  localparam int ENTRIES_DEF   = 64;
  localparam int ID_BITS_DEF   = 15;
  localparam int CFG_MAX       = 127;  // largest entries_in_use value
  localparam int CFG_RESET     = 64;

  localparam int COUNT_W = 7;
  localparam int OWNER_W = 15;
  localparam int INDEX_W = 6;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_INVALID = 2'd1,
    STATUS_NOROOM  = 2'd2
  } status_e;

  typedef struct packed {
    logic                 req_type;
    logic [COUNT_W-1:0]   count_needed;
    logic [OWNER_W-1:0]   owner_id;
    logic [INDEX_W-1:0]   start_index;
  } req_t;

  typedef struct packed {
    status_e              status;
    logic [INDEX_W-1:0]   base_index;
    logic [COUNT_W-1:0]   freed_count;
  } rsp_t;

  typedef struct packed {
    logic en;
    logic valid;
  } tbl_wr_t;

endpackage

`default_nettype wire

// ===== hdl/cba_table.sv =====
// ----------------------------------------------------------------------------
// cba_table
// Entry table: valid bits in flops cleared at reset, owner ids in a RAM.
// ----------------------------------------------------------------------------
`default_nettype none

module cba_table #(
  parameter int DEPTH   = cba_pkg::ENTRIES_DEF,
  parameter int ID_BITS = cba_pkg::ID_BITS_DEF,
  parameter int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic [AW-1:0]       rd_addr_i,
  output logic                     rd_valid_o,
  output logic [ID_BITS-1:0]       rd_owner_o,
  input  wire cba_pkg::tbl_wr_t    wr_i,
  input  wire logic [AW-1:0]       wr_addr_i,
  input  wire logic [ID_BITS-1:0]  wr_owner_i
);

  logic [DEPTH-1:0]   valid_q;
  logic [ID_BITS-1:0] mem [DEPTH];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_i.en) begin
      valid_q[wr_addr_i] <= wr_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en && wr_i.valid) begin
      mem[wr_addr_i] <= wr_owner_i;
    end
    rd_owner_o <= mem[rd_addr_i];
  end

  assign rd_valid_o = valid_q[rd_addr_i];

endmodule

`default_nettype wire

// ===== hdl/contiguous_block_allocator.sv =====
// ----------------------------------------------------------------------------
// contiguous_block_allocator
// Next-fit allocator of contiguous entry runs with tagged owners.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; busy stays high
// until the result, which appears for one cycle with done_o and cannot be
// held off. An allocate runs a next-fit scan that looks at one valid bit a
// cycle, up to n entries on the first pass and n on the retry from entry 0
// (n = managed entries), then tags the block one entry a cycle. A free
// checks each entry in two states, a registered RAM read (FRD) and then a
// compare (FCMP), since each owner id comes out of the registered RAM read
// port. Invalid requests are answered from idle without raising busy. The
// table is ready right after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module contiguous_block_allocator #(
  parameter int ENTRIES = cba_pkg::ENTRIES_DEF,
  parameter int ID_BITS = cba_pkg::ID_BITS_DEF
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  output logic               busy,
  input  wire cba_pkg::req_t req_i,
  output logic               done_o,
  output cba_pkg::rsp_t      rsp_o,
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire logic [2:0]    paddr,
  input  wire logic [31:0]   pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int DEPTH = (ENTRIES < cba_pkg::CFG_MAX) ? ENTRIES : cba_pkg::CFG_MAX;
  localparam int IW    = $clog2(DEPTH + 1);
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = cba_pkg::COUNT_W;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SEARCH = 3'd1;
  localparam logic [2:0] ST_TAG    = 3'd2;
  localparam logic [2:0] ST_FRD    = 3'd3;
  localparam logic [2:0] ST_FCMP   = 3'd4;

  logic [2:0]         state_q, state_d;
  logic [CW-1:0]      eiu_q;
  logic [IW-1:0]      hint_q, hint_d;
  logic [IW-1:0]      first_q, first_d;
  logic [IW-1:0]      pos_q, pos_d;
  logic [IW-1:0]      cur_q, cur_d;
  logic [IW-1:0]      need_q, need_d;
  logic [ID_BITS-1:0] owner_q, owner_d;
  logic               pass_q, pass_d;
  logic [CW-1:0]      freed_q, freed_d;
  logic               done_q, done_d;
  cba_pkg::rsp_t      rsp_q, rsp_d;

  logic [IW-1:0]      n;
  logic [IW:0]        sum;
  logic               owner_oor;
  logic               cfg_wr;

  logic [AW-1:0]      rd_addr;
  logic               rd_valid;
  logic [ID_BITS-1:0] rd_owner;
  cba_pkg::tbl_wr_t   tbl_wr;

  assign cfg_wr = psel && penable && pwrite && !paddr[2];
  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : {{(32 - CW){1'b0}}, eiu_q};

  assign n = (eiu_q > CW'(DEPTH)) ? IW'(DEPTH) : IW'(eiu_q);
  assign sum = (IW + 1)'(first_q) + (IW + 1)'(need_q);
  assign owner_oor = (req_i.owner_id >> ID_BITS) != '0;

  assign busy   = state_q != ST_IDLE;
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  assign rd_addr = (state_q == ST_SEARCH) ? pos_q[AW-1:0] : cur_q[AW-1:0];

  cba_table #(
    .DEPTH   (DEPTH),
    .ID_BITS (ID_BITS),
    .AW      (AW)
  ) u_table (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_addr_i  (rd_addr),
    .rd_valid_o (rd_valid),
    .rd_owner_o (rd_owner),
    .wr_i       (tbl_wr),
    .wr_addr_i  (cur_q[AW-1:0]),
    .wr_owner_i (owner_q)
  );

  always_comb begin
    state_d  = state_q;
    hint_d   = hint_q;
    first_d  = first_q;
    pos_d    = pos_q;
    cur_d    = cur_q;
    need_d   = need_q;
    owner_d  = owner_q;
    pass_d   = pass_q;
    freed_d  = freed_q;
    done_d   = 1'b0;
    rsp_d    = rsp_q;
    tbl_wr   = '{en: 1'b0, valid: 1'b0};

    case (state_q)
      ST_IDLE: begin
        if (start) begin
          owner_d = req_i.owner_id[ID_BITS-1:0];
          need_d  = IW'(req_i.count_needed);
          freed_d = '0;
          pass_d  = 1'b0;
          first_d = hint_q;
          pos_d   = hint_q;
          cur_d   = IW'(req_i.start_index);
          rsp_d   = '{status: cba_pkg::STATUS_OK, base_index: '0, freed_count: '0};
          if (req_i.req_type == cba_pkg::REQ_ALLOC) begin
            if (req_i.count_needed == '0 || req_i.count_needed > CW'(n) || owner_oor) begin
              rsp_d.status = cba_pkg::STATUS_INVALID;
              done_d       = 1'b1;
            end else begin
              state_d = ST_SEARCH;
            end
          end else begin
            if ({1'b0, req_i.start_index} >= CW'(n)) begin
              rsp_d.status = cba_pkg::STATUS_INVALID;
              done_d       = 1'b1;
            end else if (owner_oor) begin
              done_d = 1'b1;
            end else begin
              state_d = ST_FRD;
            end
          end
        end
      end
      ST_SEARCH: begin
        if (sum > (IW + 1)'(n)) begin
          hint_d  = '0;
          first_d = '0;
          pos_d   = '0;
          if (!pass_q) begin
            pass_d = 1'b1;
          end else begin
            rsp_d.status = cba_pkg::STATUS_NOROOM;
            done_d       = 1'b1;
            state_d      = ST_IDLE;
          end
        end else if ((IW + 1)'(pos_q) == sum) begin
          cur_d   = first_q;
          state_d = ST_TAG;
        end else begin
          if (rd_valid) begin
            first_d = pos_q + 1'b1;
          end
          pos_d = pos_q + 1'b1;
        end
      end
      ST_TAG: begin
        tbl_wr = '{en: 1'b1, valid: 1'b1};
        cur_d  = cur_q + 1'b1;
        if (cur_d == pos_q) begin
          hint_d           = (pos_q == n) ? '0 : pos_q;
          rsp_d.base_index = cba_pkg::INDEX_W'(first_q);
          done_d           = 1'b1;
          state_d          = ST_IDLE;
        end
      end
      ST_FRD: begin
        state_d = ST_FCMP;
      end
      ST_FCMP: begin
        if (rd_valid && rd_owner == owner_q) begin
          tbl_wr  = '{en: 1'b1, valid: 1'b0};
          freed_d = freed_q + 1'b1;
          cur_d   = cur_q + 1'b1;
          if (cur_d == n) begin
            rsp_d.freed_count = freed_d;
            done_d            = 1'b1;
            state_d           = ST_IDLE;
          end else begin
            state_d = ST_FRD;
          end
        end else begin
          rsp_d.freed_count = freed_q;
          done_d            = 1'b1;
          state_d           = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      hint_q  <= '0;
      done_q  <= 1'b0;
      eiu_q   <= CW'(cba_pkg::CFG_RESET);
    end else begin
      state_q <= state_d;
      hint_q  <= hint_d;
      done_q  <= done_d;
      if (cfg_wr) begin
        eiu_q <= pwdata[CW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    first_q <= first_d;
    pos_q   <= pos_d;
    cur_q   <= cur_d;
    need_q  <= need_d;
    owner_q <= owner_d;
    pass_q  <= pass_d;
    freed_q <= freed_d;
    rsp_q   <= rsp_d;
  end

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy || done_o))
    else $error("request accepted but neither busy nor done");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while still busy");

  a_noroom_hint: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.status == cba_pkg::STATUS_NOROOM)
      |-> (hint_q == '0 && rsp_o.base_index == '0))
    else $error("failed allocate left hint or base set");

  a_hint_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hint_q < IW'(DEPTH))
    else $error("search hint beyond table");

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the next-fit contiguous block allocator.
// A directed table covers the request extremes, invalid and no-room cases,
// full-table allocation and owner-matched frees. Random allocate and free
// traffic then follows, driven from a live copy of the entry table, under
// several entries_in_use settings including 0, 1, 64 and 127. Each response
// is checked against its typed row or a model of the table and next-fit hint.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0]  ADDR_ENTRIES = 3'd0;
  localparam int          VALID_BIT    = cba_pkg::ID_BITS_DEF;
  localparam logic [14:0] OWNER_MAX    = 15'h7FFF;

  typedef struct {
    cba_pkg::req_t  req;
    bit             typed;
    cba_pkg::rsp_t  rsp;
  } dir_row_t;

  logic          clk_i   = 1'b0;
  logic          rst_ni  = 1'b0;
  logic          start   = 1'b0;
  cba_pkg::req_t req_d   = '0;
  logic          psel    = 1'b0;
  logic          penable = 1'b0;
  logic          pwrite  = 1'b0;
  logic [2:0]    paddr   = '0;
  logic [31:0]   pwdata  = '0;
  logic          busy;
  logic          done_o;
  cba_pkg::rsp_t rsp_o;
  logic [31:0]   prdata;
  logic          pready;

  logic [15:0] owner_tags [cba_pkg::ENTRIES_DEF];
  int          next_fit_pos;
  logic [6:0]  cfg_entries;

  cba_pkg::rsp_t rsp_fifo [$];
  dir_row_t      dir_rows [$];
  int            errors;
  int            n_requests, n_placed, n_noroom, n_rejected, n_freed, n_settings;

  contiguous_block_allocator DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .req_i   (req_d),
    .done_o  (done_o),
    .rsp_o   (rsp_o),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  initial begin
    #20_000_000;
    $display("Mismatches found");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    errors++;
    $display("ERROR at %0t: %s", $realtime, msg);
  endtask

  function automatic int managed_entries();
    return (cfg_entries > cba_pkg::ENTRIES_DEF) ? cba_pkg::ENTRIES_DEF : int'(cfg_entries);
  endfunction

  function automatic bit fit_block(input int n, input int need, input logic [15:0] tag,
                                   output int base);
    int first, pos, k;
    first = next_fit_pos;
    pos   = first;
    base  = 0;
    forever begin
      if (first + need > n) return 1'b0;
      if (pos == first + need) break;
      if (owner_tags[pos][VALID_BIT]) first = pos + 1;
      pos++;
    end
    for (k = first; k < pos; k++) owner_tags[k] = tag;
    next_fit_pos = (pos == n) ? 0 : pos;
    base = first;
    return 1'b1;
  endfunction

  function automatic cba_pkg::rsp_t model_request(input cba_pkg::req_t r);
    cba_pkg::rsp_t o;
    int            n, base, k, freed;
    logic [15:0]   tag;
    o        = '0;
    o.status = cba_pkg::STATUS_OK;
    n        = managed_entries();
    tag      = {1'b1, r.owner_id};
    freed    = 0;
    if (r.req_type == cba_pkg::REQ_ALLOC) begin
      if (r.count_needed == 0 || int'(r.count_needed) > n) begin
        o.status = cba_pkg::STATUS_INVALID;
      end else begin
        if (!fit_block(n, r.count_needed, tag, base)) begin
          next_fit_pos = 0;
          if (!fit_block(n, r.count_needed, tag, base)) o.status = cba_pkg::STATUS_NOROOM;
        end
        if (o.status == cba_pkg::STATUS_OK) o.base_index = base[5:0];
      end
    end else begin
      if (int'(r.start_index) >= n) begin
        o.status = cba_pkg::STATUS_INVALID;
      end else begin
        for (k = r.start_index; k < n && owner_tags[k] == tag; k++) begin
          owner_tags[k] = '0;
          freed++;
        end
        o.freed_count = freed[6:0];
      end
    end
    return o;
  endfunction

  task automatic issue(input cba_pkg::req_t r, input bit typed, input cba_pkg::rsp_t typed_rsp);
    cba_pkg::rsp_t want;
    start <= 1'b1;
    req_d <= r;
    do @(posedge clk_i); while (busy);
    want = model_request(r);
    if (typed) want = typed_rsp;
    rsp_fifo.push_back(want);
    n_requests++;
    case (want.status)
      cba_pkg::STATUS_OK: begin
        if (r.req_type == cba_pkg::REQ_ALLOC) n_placed++;
        n_freed += want.freed_count;
      end
      cba_pkg::STATUS_NOROOM: n_noroom++;
      default: n_rejected++;
    endcase
  endtask

  function automatic int pick_gap(input bit burst);
    int p;
    if (burst) return 0;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 85) return $urandom_range(1, 3);
    if (p < 97) return $urandom_range(4, 20);
    return $urandom_range(30, 120);
  endfunction

  task automatic idle_gap(input int cycles);
    if (cycles > 0) begin
      start <= 1'b0;
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (rsp_fifo.size() != 0 || busy) @(posedge clk_i);
  endtask

  task automatic write_entries(input logic [6:0] v);
    logic [31:0] rd;
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_ENTRIES;
    pwdata  <= {25'($urandom), v};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    cfg_entries = v;
    n_settings++;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rd[6:0] != v)
      report_mismatch($sformatf("entries_in_use reads %0d, wrote %0d", rd[6:0], v));
  endtask

  task automatic add_row(input logic kind, input int cnt, input logic [14:0] owner,
                         input int idx, input bit typed, input cba_pkg::status_e st,
                         input int base, input int freed);
    dir_row_t row;
    row.req.req_type     = kind;
    row.req.count_needed = cnt[6:0];
    row.req.owner_id     = owner;
    row.req.start_index  = idx[5:0];
    row.typed            = typed;
    row.rsp.status       = st;
    row.rsp.base_index   = base[5:0];
    row.rsp.freed_count  = freed[6:0];
    dir_rows.push_back(row);
  endtask

  function automatic logic [14:0] pick_owner();
    int p;
    p = $urandom_range(0, 9);
    case (p)
      0: return 15'h0000;
      1: return 15'h0001;
      2: return OWNER_MAX;
      3: return 15'h5555;
      4: return 15'h2AAA;
      5, 6: return 15'h0002;
      default: return 15'($urandom_range(0, 32767));
    endcase
  endfunction

  function automatic cba_pkg::req_t random_request();
    cba_pkg::req_t r;
    int            n, p, i, j, lim;
    n = managed_entries();
    r = '0;
    r.owner_id     = pick_owner();
    r.start_index  = 6'($urandom);
    r.count_needed = 7'($urandom);
    if ($urandom_range(0, 99) < 55) begin
      r.req_type = cba_pkg::REQ_ALLOC;
      p = $urandom_range(0, 99);
      if (n == 0) begin
        r.count_needed = 7'($urandom_range(0, 127));
      end else if (p < 60) begin
        lim = (n < 8) ? n : 8;
        r.count_needed = 7'($urandom_range(1, lim));
      end else if (p < 82) begin
        r.count_needed = 7'($urandom_range(1, n));
      end else if (p < 90) begin
        r.count_needed = 7'(n);
      end else if (p < 95) begin
        r.count_needed = '0;
      end else begin
        r.count_needed = 7'($urandom_range(n + 1, 127));
      end
    end else begin
      r.req_type = cba_pkg::REQ_FREE;
      if (n > 0 && $urandom_range(0, 99) < 70) begin
        i = $urandom_range(0, n - 1);
        for (j = i; j < n && !owner_tags[j][VALID_BIT]; j++) ;
        if (j < n) begin
          r.start_index = j[5:0];
          r.owner_id    = owner_tags[j][14:0];
        end
      end
    end
    return r;
  endfunction

  always @(posedge clk_i) begin
    cba_pkg::rsp_t want;
    if (rst_ni && done_o) begin
      if (rsp_fifo.size() == 0) begin
        report_mismatch("response with no request outstanding");
      end else begin
        want = rsp_fifo.pop_front();
        if (rsp_o.status !== want.status)
          report_mismatch($sformatf("status %0d, expected %0d", rsp_o.status, want.status));
        if (rsp_o.base_index !== want.base_index)
          report_mismatch($sformatf("base_index %0d, expected %0d",
                                    rsp_o.base_index, want.base_index));
        if (rsp_o.freed_count !== want.freed_count)
          report_mismatch($sformatf("freed_count %0d, expected %0d",
                                    rsp_o.freed_count, want.freed_count));
      end
    end
  end

  initial begin
    int            phase_cfg [7];
    int            phase_len [7];
    bit            burst;
    cba_pkg::rsp_t none;
    int            ph, it;

    phase_cfg = '{64, 1, 127, 5, 0, 33, 64};
    phase_len = '{60, 40, 60, 60, 20, 60, 60};
    none = '0;
    foreach (owner_tags[k]) owner_tags[k] = '0;
    next_fit_pos = 0;
    cfg_entries = 7'(cba_pkg::CFG_RESET);

    // typed rows: fresh table, reset setting of 64 entries
    add_row(cba_pkg::REQ_ALLOC, 0,   15'd3,     0,  1, cba_pkg::STATUS_INVALID, 0, 0);
    add_row(cba_pkg::REQ_ALLOC, 65,  15'd3,     0,  1, cba_pkg::STATUS_INVALID, 0, 0);
    add_row(cba_pkg::REQ_ALLOC, 127, 15'd3,     63, 1, cba_pkg::STATUS_INVALID, 0, 0);
    add_row(cba_pkg::REQ_ALLOC, 64,  OWNER_MAX, 0,  1, cba_pkg::STATUS_OK,      0, 0);
    add_row(cba_pkg::REQ_ALLOC, 1,   15'd1,     0,  1, cba_pkg::STATUS_NOROOM,  0, 0);
    add_row(cba_pkg::REQ_FREE,  0,   15'h7FFE,  63, 1, cba_pkg::STATUS_OK,      0, 0);
    add_row(cba_pkg::REQ_FREE,  127, OWNER_MAX, 0,  1, cba_pkg::STATUS_OK,      0, 64);
    // model-checked rows
    add_row(cba_pkg::REQ_FREE,  0,  15'd0,    0,  0, cba_pkg::STATUS_OK, 0, 0);
    add_row(cba_pkg::REQ_ALLOC, 3,  15'd5,    0,  0, cba_pkg::STATUS_OK, 0, 0);
    add_row(cba_pkg::REQ_ALLOC, 2,  15'd6,    0,  0, cba_pkg::STATUS_OK, 0, 0);
    add_row(cba_pkg::REQ_ALLOC, 1,  15'd7,    0,  0, cba_pkg::STATUS_OK, 0, 0);
    add_row(cba_pkg::REQ_FREE,  0,  15'd6,    3,  0, cba_pkg::STATUS_OK, 0, 0);
    add_row(cba_pkg::REQ_ALLOC, 60, 15'd8,    0,  0, cba_pkg::STATUS_OK, 0, 0);
    add_row(cba_pkg::REQ_ALLOC, 58, 15'd9,    0,  0, cba_pkg::STATUS_OK, 0, 0);
    add_row(cba_pkg::REQ_ALLOC, 2,  15'd10,   0,  0, cba_pkg::STATUS_OK, 0, 0);
    add_row(cba_pkg::REQ_FREE,  0,  15'd9,    63, 0, cba_pkg::STATUS_OK, 0, 0);
    add_row(cba_pkg::REQ_FREE,  0,  15'd1,    62, 0, cba_pkg::STATUS_OK, 0, 0);
    add_row(cba_pkg::REQ_FREE,  0,  15'd9,    6,  0, cba_pkg::STATUS_OK, 0, 0);
    add_row(cba_pkg::REQ_ALLOC, 4,  15'h5555, 0,  0, cba_pkg::STATUS_OK, 0, 0);
    add_row(cba_pkg::REQ_ALLOC, 63, 15'h2AAA, 0,  0, cba_pkg::STATUS_OK, 0, 0);
    add_row(cba_pkg::REQ_FREE,  0,  15'd5,    0,  0, cba_pkg::STATUS_OK, 0, 0);

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      issue(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].rsp);
      idle_gap(pick_gap(1'b0));
    end
    drain();

    for (ph = 0; ph < 7; ph++) begin
      repeat (4) @(posedge clk_i);
      write_entries(7'(phase_cfg[ph]));
      @(posedge clk_i);
      burst = 1'b0;
      for (it = 0; it < phase_len[ph]; it++) begin
        if (it % 16 == 0) burst = ($urandom_range(0, 3) == 0);
        issue(random_request(), 1'b0, none);
        if ($urandom_range(0, 29) == 0) drain();
        else idle_gap(pick_gap(burst));
      end
      drain();
    end

    repeat (200) @(posedge clk_i);
    if (rsp_fifo.size() != 0)
      report_mismatch($sformatf("%0d responses never arrived", rsp_fifo.size()));

    $display("Ran %0d requests: %0d blocks placed, %0d without room, %0d rejected, %0d freed",
             n_requests, n_placed, n_noroom, n_rejected, n_freed);
    $display("Table size settings applied: %0d", n_settings);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
